// ===== src/rcl_pkg.sv =====
// Shared constants and types for the recent colour recency list.
package rcl_pkg;

	localparam int DEPTH = 8;
	localparam int COLOR_W = 32;
	localparam int KEY_W = 24;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int POS_W = 3;
	localparam int FILL_W = 4;

	typedef struct packed {
		logic accept;
		logic full_miss;
		logic is_target;
	} cell_ctl_t;

endpackage

// ===== src/recent_color_lru_list.sv =====
// Top level of the recent colour recency list: cell chain, fill count and result register.
// One colour beat is taken per clock and its result appears in the output register on the
// next cycle; the block keeps taking beats while the result register is free or being
// emptied, so the sustained rate is one colour per cycle. That cycle is set by the key
// compare in every cell and the first-match ripple along the chain of DEPTH cells. The
// list holds colours oldest first; a match on the RGB part (alpha ignored) moves the entry
// to the newest end with the new alpha, and a miss on a full list drops and reports the
// oldest entry. No clearing pass is needed after reset.
module recent_color_lru_list (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [rcl_pkg::COLOR_W-1:0]    color,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           hit,
	output logic [rcl_pkg::POS_W-1:0]      hit_position,
	output logic                           evicted,
	output logic [rcl_pkg::COLOR_W-1:0]    evicted_color,
	output logic [rcl_pkg::FILL_W-1:0]     fill_count
);

	logic [rcl_pkg::CNT_W-1:0]   occ_q;
	logic [rcl_pkg::CNT_W-1:0]   occ_next;
	logic [rcl_pkg::CNT_W-1:0]   target;
	logic                        accept;
	logic                        full;
	logic                        any_hit;
	logic                        full_miss;
	logic [rcl_pkg::IDX_W-1:0]   pos;
	logic [rcl_pkg::DEPTH:0]     found;
	logic [rcl_pkg::DEPTH-1:0]   first;
	logic [rcl_pkg::DEPTH-1:0]   valid;
	logic [rcl_pkg::COLOR_W-1:0] entry [rcl_pkg::DEPTH+1];
	rcl_pkg::cell_ctl_t          ctl [rcl_pkg::DEPTH];

	logic                        out_valid_q;
	logic                        hit_q;
	logic [rcl_pkg::POS_W-1:0]   hit_position_q;
	logic                        evicted_q;
	logic [rcl_pkg::COLOR_W-1:0] evicted_color_q;
	logic [rcl_pkg::FILL_W-1:0]  fill_count_q;

	assign in_stall = out_valid_q & out_stall;
	assign accept = in_valid & ~in_stall;
	assign full = (occ_q == rcl_pkg::CNT_W'(rcl_pkg::DEPTH));
	assign found[0] = 1'b0;
	assign any_hit = found[rcl_pkg::DEPTH];
	assign full_miss = full & ~any_hit;
	assign target = (any_hit | full) ? occ_q - 1'b1 : occ_q;
	assign occ_next = (any_hit | full) ? occ_q : occ_q + 1'b1;
	assign entry[rcl_pkg::DEPTH] = color;

	for (genvar i = 0; i < rcl_pkg::DEPTH; i++) begin : g_cell
		assign valid[i] = (rcl_pkg::CNT_W'(i) < occ_q);
		assign ctl[i] = '{
			accept:    accept,
			full_miss: full_miss,
			is_target: (target == rcl_pkg::CNT_W'(i))
		};
		rcl_cell u_cell (
			.clk        (clk),
			.color      (color),
			.valid      (valid[i]),
			.ctl        (ctl[i]),
			.found_in   (found[i]),
			.next_entry (entry[i+1]),
			.found_out  (found[i+1]),
			.first      (first[i]),
			.entry      (entry[i])
		);
	end

	always_comb begin
		pos = '0;
		for (int i = 0; i < rcl_pkg::DEPTH; i++) begin
			if (first[i]) begin
				pos = pos | rcl_pkg::IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				occ_q <= occ_next;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q <= any_hit;
			hit_position_q <= rcl_pkg::POS_W'(pos);
			evicted_q <= full_miss;
			evicted_color_q <= full_miss ? entry[0] : '0;
			fill_count_q <= rcl_pkg::FILL_W'(occ_next);
		end
	end

	assign out_valid = out_valid_q;
	assign hit = hit_q;
	assign hit_position = hit_position_q;
	assign evicted = evicted_q;
	assign evicted_color = evicted_color_q;
	assign fill_count = fill_count_q;

`ifndef SYNTH
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= rcl_pkg::CNT_W'(rcl_pkg::DEPTH))
		else $error("fill count beyond depth");

	a_single_first: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first) && (any_hit == (first != '0)))
		else $error("match chain disagrees with first match");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(hit_q && evicted_q))
		else $error("hit and eviction on one beat");

	a_occ_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !any_hit && !full) |=> (occ_q == $past(occ_q) + 1'b1))
		else $error("fill count did not advance on a miss with room");
`endif

endmodule

// ===== src/rcl_cell.sv =====
// One list position: holds an entry, compares its key and shifts towards the oldest end.
module rcl_cell (
	input  logic                           clk,
	input  logic [rcl_pkg::COLOR_W-1:0]    color,
	input  logic                           valid,
	input  rcl_pkg::cell_ctl_t             ctl,
	input  logic                           found_in,
	input  logic [rcl_pkg::COLOR_W-1:0]    next_entry,
	output logic                           found_out,
	output logic                           first,
	output logic [rcl_pkg::COLOR_W-1:0]    entry
);

	logic [rcl_pkg::COLOR_W-1:0] entry_q;
	logic                        match;
	logic                        load;

	assign match = valid &&
		(entry_q[rcl_pkg::KEY_W-1:0] == color[rcl_pkg::KEY_W-1:0]);
	assign found_out = found_in | match;
	assign first = match & ~found_in;
	assign load = ctl.accept & (found_out | ctl.full_miss | ctl.is_target);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= ctl.is_target ? color : next_entry;
		end
	end

endmodule

// ===== dv/tb.sv =====
// Testbench for the recent colour recency list: directed table, random colours, self-checking.
`timescale 1ns / 100ps

module tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BEATS = 1400;
	localparam int HOLD_CYCLES = 300;
	localparam int POOL_N = 12;

	typedef struct packed {
		logic                          hit;
		logic [rcl_pkg::POS_W-1:0]     pos;
		logic                          evicted;
		logic [rcl_pkg::COLOR_W-1:0]   ev_color;
		logic [rcl_pkg::FILL_W-1:0]    fill;
	} colour_result_t;

	typedef struct {
		logic [rcl_pkg::COLOR_W-1:0]   color;
		bit                            typed;
		colour_result_t                want;
	} stim_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [rcl_pkg::COLOR_W-1:0]   color;
	logic                          out_valid;
	logic                          out_stall;
	logic                          hit;
	logic [rcl_pkg::POS_W-1:0]     hit_position;
	logic                          evicted;
	logic [rcl_pkg::COLOR_W-1:0]   evicted_color;
	logic [rcl_pkg::FILL_W-1:0]    fill_count;

	logic [rcl_pkg::COLOR_W-1:0]   palette [rcl_pkg::DEPTH];
	int                            held;
	colour_result_t                pending_results [$];
	stim_row_t                     directed [$];
	logic [rcl_pkg::KEY_W-1:0]     key_pool [POOL_N];
	int                            beats_sent;
	int                            errors;
	int                            cycles;

	recent_color_lru_list dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.color         (color),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hit           (hit),
		.hit_position  (hit_position),
		.evicted       (evicted),
		.evicted_color (evicted_color),
		.fill_count    (fill_count)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic colour_result_t predict_recent(input logic [rcl_pkg::COLOR_W-1:0] c);
		colour_result_t r;
		int found;
		int n;
		r = '0;
		found = -1;
		n = held;
		for (int i = 0; i < n; i++)
			if (found < 0 && palette[i][rcl_pkg::KEY_W-1:0] == c[rcl_pkg::KEY_W-1:0])
				found = i;
		if (found >= 0) begin
			r.hit = 1'b1;
			r.pos = found[rcl_pkg::POS_W-1:0];
			for (int i = found; i < n - 1; i++)
				palette[i] = palette[i + 1];
			palette[n - 1] = c;
		end else if (n == rcl_pkg::DEPTH) begin
			r.evicted = 1'b1;
			r.ev_color = palette[0];
			for (int i = 0; i < rcl_pkg::DEPTH - 1; i++)
				palette[i] = palette[i + 1];
			palette[rcl_pkg::DEPTH - 1] = c;
		end else begin
			palette[n] = c;
			held = n + 1;
		end
		r.fill = held[rcl_pkg::FILL_W-1:0];
		return r;
	endfunction

	function automatic bit calm_stretch();
		return beats_sent >= 300 && beats_sent < 500;
	endfunction

	task automatic report_mismatch(input string field, input logic [rcl_pkg::COLOR_W-1:0] got,
			input logic [rcl_pkg::COLOR_W-1:0] want);
		errors++;
		$display("mismatch %s at cycle %0d: got %0h expected %0h", field, cycles, got, want);
	endtask

	task automatic add_row(input logic [rcl_pkg::COLOR_W-1:0] c, input bit typed, input logic h,
			input int p, input logic e, input logic [rcl_pkg::COLOR_W-1:0] ec, input int f);
		stim_row_t row;
		row.color = c;
		row.typed = typed;
		row.want = '{h, p[rcl_pkg::POS_W-1:0], e, ec, f[rcl_pkg::FILL_W-1:0]};
		directed.push_back(row);
	endtask

	task automatic send_beat(input logic [rcl_pkg::COLOR_W-1:0] c, input bit typed,
			input colour_result_t want);
		colour_result_t got;
		@(negedge clk);
		while (!calm_stretch() && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		color <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = predict_recent(c);
		pending_results.push_back(typed ? want : got);
		beats_sent++;
	endtask

	function automatic logic [rcl_pkg::COLOR_W-1:0] next_colour();
		logic [rcl_pkg::COLOR_W-1:0] c;
		c = $urandom;
		if ($urandom_range(99) < 60)
			c[rcl_pkg::KEY_W-1:0] = key_pool[$urandom_range(POOL_N - 1)];
		return c;
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin : watch_results
		colour_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", '0, '0);
			end else begin
				want = pending_results.pop_front();
				if (hit !== want.hit)
					report_mismatch("hit", rcl_pkg::COLOR_W'(hit),
						rcl_pkg::COLOR_W'(want.hit));
				if (hit_position !== want.pos)
					report_mismatch("hit_position", rcl_pkg::COLOR_W'(hit_position),
						rcl_pkg::COLOR_W'(want.pos));
				if (evicted !== want.evicted)
					report_mismatch("evicted", rcl_pkg::COLOR_W'(evicted),
						rcl_pkg::COLOR_W'(want.evicted));
				if (evicted_color !== want.ev_color)
					report_mismatch("evicted_color", evicted_color, want.ev_color);
				if (fill_count !== want.fill)
					report_mismatch("fill_count", rcl_pkg::COLOR_W'(fill_count),
						rcl_pkg::COLOR_W'(want.fill));
			end
		end
	end

	initial begin : drive_stall
		int hold_left;
		bit held_once;
		hold_left = 0;
		held_once = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_once && beats_sent >= 700) begin
				held_once = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (calm_stretch()) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 35);
			end
		end
	end

	initial begin : drive_colours
		colour_result_t none;
		none = '0;
		in_valid = 1'b0;
		color = '0;
		arst_n = 1'b0;
		held = 0;
		beats_sent = 0;
		errors = 0;
		cycles = 0;
		for (int i = 0; i < POOL_N; i++)
			key_pool[i] = rcl_pkg::KEY_W'($urandom);

		add_row(32'h0000_0000, 1, 0, 0, 0, '0, 1);
		add_row(32'hFFFF_FFFF, 1, 0, 0, 0, '0, 2);
		add_row(32'hFF00_0000, 1, 1, 0, 0, '0, 2);
		add_row(32'h00FF_FFFF, 1, 1, 0, 0, '0, 2);
		add_row(32'hAAAA_AAAA, 0, 0, 0, 0, '0, 0);
		add_row(32'h5555_5555, 0, 0, 0, 0, '0, 0);
		add_row(32'h0101_0101, 0, 0, 0, 0, '0, 0);
		add_row(32'h8080_8080, 0, 0, 0, 0, '0, 0);
		add_row(32'h7F7F_7F7F, 0, 0, 0, 0, '0, 0);
		add_row(32'h1234_5678, 1, 0, 0, 0, '0, 8);
		add_row(32'h0000_FFFF, 1, 0, 0, 1, 32'hFF00_0000, 8);
		add_row(32'hAB34_5678, 0, 0, 0, 0, '0, 0);
		add_row(32'h8000_FFFF, 0, 0, 0, 0, '0, 0);
		add_row(32'h00FF_FFFF, 0, 0, 0, 0, '0, 0);
		add_row(32'h5A80_8080, 0, 0, 0, 0, '0, 0);
		add_row(32'hFEDC_BA98, 0, 0, 0, 0, '0, 0);
		add_row(32'h0000_0001, 0, 0, 0, 0, '0, 0);
		add_row(32'h0080_0000, 0, 0, 0, 0, '0, 0);
		add_row(32'h0100_0000, 0, 0, 0, 0, '0, 0);
		add_row(32'hFF80_0000, 0, 0, 0, 0, '0, 0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_beat(directed[i].color, directed[i].typed, directed[i].want);

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (i == 1000) begin
				@(negedge clk);
				in_valid <= 1'b0;
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			if (i % 100 == 99)
				key_pool[$urandom_range(POOL_N - 1)] = rcl_pkg::KEY_W'($urandom);
			send_beat(next_colour(), 0, none);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
src/rcl_pkg.sv
src/rcl_cell.sv
src/recent_color_lru_list.sv
dv/tb.sv
